// ----- hdl/assert_macros.svh -----
// assertion macros used by the console controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TCT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define TCT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define TCT_ASSERT(lbl, clk, rst, prop)
`define TCT_NEVER(lbl, clk, rst, expr)
`endif
`endif

// ----- hdl/tct_pkg.sv -----
// types and constants of the text console
`timescale 1ns / 1ps
`default_nettype none

package tct_pkg;

  localparam int KIND_W      = 2;
  localparam int CODE_W      = 8;
  localparam int INDEX_W     = 11;
  localparam int COL_OUT_W   = 7;
  localparam int ROW_OUT_W   = 5;
  localparam int WORD_W      = 16;
  localparam int COLOR_W     = 4;
  localparam int TAB_W       = 5;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 5;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t CFG_FOREGROUND = 2'd0;
  localparam cfg_index_t CFG_BACKGROUND = 2'd1;
  localparam cfg_index_t CFG_TAB_STRIDE = 2'd2;

  localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 4'hF;
  localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 4'h0;
  localparam logic [TAB_W-1:0]   TAB_STRIDE_RESET = 5'd8;

  localparam logic [CODE_W-1:0] CH_BS         = 8'h08;
  localparam logic [CODE_W-1:0] CH_TAB        = 8'h09;
  localparam logic [CODE_W-1:0] CH_LF         = 8'h0A;
  localparam logic [CODE_W-1:0] CH_CR         = 8'h0D;
  localparam logic [CODE_W-1:0] CH_SPACE      = 8'h20;
  localparam logic [CODE_W-1:0] CH_PRINT_LAST = 8'h7F;

  localparam logic [WORD_W-1:0] CELL_RESET = 16'h0F20;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCROLL,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    SWEEP_NONE,
    SWEEP_INIT,
    SWEEP_CLEAR,
    SWEEP_SCROLL
  } sweep_mode_t;

  typedef struct packed {
    logic        load_item;
    logic        begin_item;
    logic        put_apply;
    logic        home;
    logic        read_issue;
    logic        word_capture;
    logic        sweep_clr;
    sweep_mode_t sweep_mode;
    logic        out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              need_scroll;
    logic              fill_end;
    logic              scroll_end;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hdl/tct_ifs.sv -----
// item and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface tct_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  char_code;
  logic [10:0] cell_index;

  modport source (output valid, output kind, output char_code, output cell_index,
                  input ready);
  modport sink (input valid, input kind, input char_code, input cell_index,
                output ready);
endinterface

interface tct_result_if;
  logic        valid;
  logic        ready;
  logic [6:0]  cursor_col;
  logic [4:0]  cursor_row;
  logic [15:0] cell_word;
  logic        scrolled;

  modport source (output valid, output cursor_col, output cursor_row, output cell_word,
                  output scrolled, input ready);
  modport sink (input valid, input cursor_col, input cursor_row, input cell_word,
                input scrolled, output ready);
endinterface

`default_nettype wire

// ----- hdl/tct_datapath.sv -----
// console datapath: cursor, config registers, screen memory and sweep counter
`timescale 1ns / 1ps
`default_nettype none

module tct_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tct_pkg::dp_cmd_t               cmd,
  output tct_pkg::dp_stat_t              stat,
  input  logic                           cfg_we,
  input  tct_pkg::cfg_index_t            cfg_index,
  input  logic [tct_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [tct_pkg::KIND_W-1:0]     kind,
  input  logic [tct_pkg::CODE_W-1:0]     char_code,
  input  logic [tct_pkg::INDEX_W-1:0]    cell_index,
  output logic [tct_pkg::COL_OUT_W-1:0]  cursor_col,
  output logic [tct_pkg::ROW_OUT_W-1:0]  cursor_row,
  output logic [tct_pkg::WORD_W-1:0]     cell_word,
  output logic                           scrolled
);
  import tct_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = AW + 1;
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int TW    = ((CW > TAB_W) ? CW : TAB_W) + 1;

  localparam logic [SW-1:0] SWEEP_FILL_END   = SW'(CELLS - 1);
  localparam logic [SW-1:0] SWEEP_SCROLL_END = SW'(CELLS);
  localparam logic [SW-1:0] COPY_END         = SW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] ROW_STEP         = AW'(COLUMNS);
  localparam logic [RW-1:0] ROW_LAST         = RW'(ROWS - 1);
  localparam logic [TW-1:0] COLS_T           = TW'(COLUMNS);
  localparam logic [31:0]   CELLS32          = 32'(CELLS);

  logic [COLOR_W-1:0] fg;
  logic [COLOR_W-1:0] bg;
  logic [TAB_W-1:0]   stride;

  logic [KIND_W-1:0]  item_kind;
  logic [CODE_W-1:0]  item_code;
  logic [INDEX_W-1:0] item_idx;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [AW-1:0] row_base;

  logic [WORD_W-1:0] word_r;
  logic              scr_r;
  logic [SW-1:0]     sweep;

  logic [WORD_W-1:0] mem [CELLS];
  logic [WORD_W-1:0] rdata;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_wdata;

  logic [WORD_W-1:0] blank;
  logic [TW-1:0]     col_ext;
  logic [TW-1:0]     stride_ext;
  logic [TW-1:0]     tab_col;
  logic [TW-1:0]     new_col;
  logic              printable;
  logic              line_feed;
  logic              wrap;
  logic              row_inc;
  logic              need_scroll;
  logic [CW-1:0]     put_col;
  logic [SW-1:0]     sweep_m1;
  logic              idx_ok;

  assign blank      = {bg, fg, CH_SPACE};
  assign col_ext    = TW'(col);
  assign stride_ext = TW'(stride);
  assign tab_col    = (col_ext + stride_ext) & ~(stride_ext - TW'(1));
  assign printable  = (item_code >= CH_SPACE) && (item_code <= CH_PRINT_LAST);
  assign sweep_m1   = sweep - SW'(1);
  assign idx_ok     = 32'(item_idx) < CELLS32;

  always_comb begin
    line_feed = 1'b0;
    case (item_code)
      CH_BS: begin
        new_col = (col != '0) ? col_ext - TW'(1) : col_ext;
      end
      CH_TAB: begin
        new_col = tab_col;
      end
      CH_CR: begin
        new_col = '0;
      end
      CH_LF: begin
        new_col   = '0;
        line_feed = 1'b1;
      end
      default: begin
        new_col = printable ? col_ext + TW'(1) : col_ext;
      end
    endcase
  end

  assign wrap        = new_col >= COLS_T;
  assign row_inc     = line_feed || wrap;
  assign need_scroll = row_inc && (row == ROW_LAST);
  assign put_col     = wrap ? '0 : CW'(new_col);

  assign stat.kind        = item_kind;
  assign stat.need_scroll = need_scroll;
  assign stat.fill_end    = sweep == SWEEP_FILL_END;
  assign stat.scroll_end  = sweep == SWEEP_SCROLL_END;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg     <= FOREGROUND_RESET;
      bg     <= BACKGROUND_RESET;
      stride <= TAB_STRIDE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FOREGROUND: fg     <= cfg_data[COLOR_W-1:0];
        CFG_BACKGROUND: bg     <= cfg_data[COLOR_W-1:0];
        CFG_TAB_STRIDE: stride <= cfg_data[TAB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_kind <= kind;
      item_code <= char_code;
      item_idx  <= cell_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      row_base <= '0;
    end else if (cmd.home) begin
      col      <= '0;
      row      <= '0;
      row_base <= '0;
    end else if (cmd.put_apply) begin
      col <= put_col;
      if (row_inc && !need_scroll) begin
        row      <= row + RW'(1);
        row_base <= row_base + ROW_STEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if (cmd.sweep_clr) begin
      sweep <= '0;
    end else if (cmd.sweep_mode != SWEEP_NONE) begin
      sweep <= sweep + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.begin_item) begin
      word_r <= '0;
      scr_r  <= cmd.put_apply && need_scroll;
    end
    if (cmd.word_capture) begin
      word_r <= idx_ok ? rdata : '0;
    end
  end

  // scroll: read cell s+COLUMNS while writing cell s-1 from the previous read
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = sweep[AW-1:0];
    mem_raddr = AW'(item_idx);
    mem_wdata = blank;
    case (cmd.sweep_mode)
      SWEEP_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = CELL_RESET;
      end
      SWEEP_CLEAR: begin
        mem_we = 1'b1;
      end
      SWEEP_SCROLL: begin
        mem_re    = sweep < COPY_END;
        mem_raddr = sweep[AW-1:0] + ROW_STEP;
        mem_we    = sweep != '0;
        mem_waddr = sweep_m1[AW-1:0];
        mem_wdata = (sweep_m1 < COPY_END) ? rdata : blank;
      end
      default: begin
        mem_re    = cmd.read_issue;
        mem_we    = cmd.put_apply && printable;
        mem_waddr = row_base + AW'(col);
        mem_wdata = {bg, fg, item_code};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cursor_col <= COL_OUT_W'(col);
      cursor_row <= ROW_OUT_W'(row);
      cell_word  <= word_r;
      scrolled   <= scr_r;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tct_ctrl.sv -----
// console controller state machine and channel handshakes
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tct_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  output logic               result_valid,
  input  logic               result_ready,
  input  tct_pkg::dp_stat_t  stat,
  output tct_pkg::dp_cmd_t   cmd
);
  import tct_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next       = state;
    item_ready       = 1'b0;
    cmd.load_item    = 1'b0;
    cmd.begin_item   = 1'b0;
    cmd.put_apply    = 1'b0;
    cmd.home         = 1'b0;
    cmd.read_issue   = 1'b0;
    cmd.word_capture = 1'b0;
    cmd.sweep_clr    = 1'b0;
    cmd.sweep_mode   = SWEEP_NONE;
    cmd.out_load     = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.sweep_mode = SWEEP_INIT;
        if (stat.fill_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        item_ready    = 1'b1;
        cmd.load_item = item_valid;
        if (item_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.begin_item = 1'b1;
        cmd.sweep_clr  = 1'b1;
        case (stat.kind)
          KIND_PUT: begin
            cmd.put_apply = 1'b1;
            state_next    = stat.need_scroll ? ST_SCROLL : ST_DONE;
          end
          KIND_CLEAR: begin
            cmd.home   = 1'b1;
            state_next = ST_CLEAR;
          end
          KIND_READ: begin
            cmd.read_issue = 1'b1;
            state_next     = ST_READ;
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end
      ST_READ: begin
        cmd.word_capture = 1'b1;
        state_next       = ST_DONE;
      end
      ST_SCROLL: begin
        cmd.sweep_mode = SWEEP_SCROLL;
        if (stat.scroll_end) begin
          state_next = ST_DONE;
        end
      end
      ST_CLEAR: begin
        cmd.sweep_mode = SWEEP_CLEAR;
        if (stat.fill_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `TCT_NEVER(a_no_overwrite, clk, rst, cmd.out_load && result_valid && !result_ready)
  `TCT_NEVER(a_no_accept_in_sweep, clk, rst, item_ready && (cmd.sweep_mode != SWEEP_NONE))
  `TCT_ASSERT(a_scroll_from_put, clk, rst, (state == ST_SCROLL && $past(state) == ST_EXEC) |-> ($past(stat.kind) == KIND_PUT))
  `TCT_ASSERT(a_result_from_done, clk, rst, $rose(result_valid) |-> ($past(state) == ST_DONE))

endmodule

`default_nettype wire

// ----- hdl/text_console_teletype.sv -----
// text console top level: controller plus datapath
// flow: an item is taken in idle and run in execute; a read then adds a read step,
// a clear a sweep over all cells and a put that scrolls a copy sweep, then done loads
// the result once the result channel is free; a new item is taken only back in idle
// reset: synchronous; homes the cursor, sets white on black and tab stride 8, then writes
// 0x0F20 to all COLUMNS*ROWS cells, one a cycle, before items are taken
`timescale 1ns / 1ps
`default_nettype none

module text_console_teletype #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  tct_pkg::cfg_index_t            cfg_index,
  input  logic [tct_pkg::CFG_DATA_W-1:0] cfg_data,
  tct_item_if.sink                       item,
  tct_result_if.source                   result
);
  import tct_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tct_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  tct_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .kind       (item.kind),
    .char_code  (item.char_code),
    .cell_index (item.cell_index),
    .cursor_col (result.cursor_col),
    .cursor_row (result.cursor_row),
    .cell_word  (result.cell_word),
    .scrolled   (result.scrolled)
  );

endmodule

`default_nettype wire

// ----- bench/text_console_teletype_tb.sv -----
// testbench for the text console: directed and random items checked against a screen predictor
`timescale 1ns / 1ps

module text_console_teletype_tb;
  import tct_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLUMNS * ROWS;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 125;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam longint LIMIT_CYCLES = 10_000_000;

  typedef struct packed {
    logic [COL_OUT_W-1:0] col;
    logic [ROW_OUT_W-1:0] row;
    logic [WORD_W-1:0] word;
    logic scrolled;
  } console_result_t;

  class console_scoreboard;
    logic [WORD_W-1:0] cells [CELLS];
    logic [31:0] col;
    logic [31:0] row;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic [TAB_W-1:0] stride;
    console_result_t awaited [$];
    int noted;
    int checked;
    int mismatches;
    int reads;
    int clears;
    int scrolls;

    function new();
      for (int i = 0; i < CELLS; i++) cells[i] = CELL_RESET;
      col = 0;
      row = 0;
      fg = FOREGROUND_RESET;
      bg = BACKGROUND_RESET;
      stride = TAB_STRIDE_RESET;
      noted = 0;
      checked = 0;
      mismatches = 0;
      reads = 0;
      clears = 0;
      scrolls = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void set_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_FOREGROUND: fg = data[COLOR_W-1:0];
        CFG_BACKGROUND: bg = data[COLOR_W-1:0];
        CFG_TAB_STRIDE: stride = data[TAB_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] code,
                            logic [INDEX_W-1:0] index);
      console_result_t want;
      logic [31:0] step;
      logic [31:0] at;
      want = '0;
      noted++;
      case (kind)
        KIND_PUT: begin
          if (code == CH_BS) begin
            if (col != 0) col = col - 1;
          end else if (code == CH_TAB) begin
            step = {27'd0, stride};
            col = (col + step) & ~(step - 32'd1);
          end else if (code == CH_CR) begin
            col = 0;
          end else if (code == CH_LF) begin
            col = 0;
            row = row + 1;
          end else if (code >= CH_SPACE && code <= CH_PRINT_LAST) begin
            at = row * COLUMNS + col;
            if (at < CELLS) cells[at] = {bg, fg, code};
            col = col + 1;
          end
          if (col >= COLUMNS) begin
            col = 0;
            row = row + 1;
          end
          // past the bottom row: shift up one row and blank the last one
          if (row >= ROWS) begin
            for (int i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++) cells[i] = {bg, fg, CH_SPACE};
            row = ROWS - 1;
            want.scrolled = 1'b1;
            scrolls++;
          end
        end
        KIND_CLEAR: begin
          for (int i = 0; i < CELLS; i++) cells[i] = {bg, fg, CH_SPACE};
          col = 0;
          row = 0;
          clears++;
        end
        KIND_READ: begin
          if (index < CELLS) want.word = cells[index];
          reads++;
        end
        default: ;
      endcase
      want.col = col[COL_OUT_W-1:0];
      want.row = row[ROW_OUT_W-1:0];
      awaited.push_back(want);
    endfunction

    function void check_result(console_result_t got);
      console_result_t want;
      checked++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing outstanding: col %0d row %0d word %h scrolled %0b",
                   $realtime, got.col, got.row, got.word, got.scrolled);
        return;
      end
      want = awaited.pop_front();
      if (got.col !== want.col || got.row !== want.row || got.word !== want.word ||
          got.scrolled !== want.scrolled) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch: expected col %0d row %0d word %h scrolled %0b",
                   $realtime, want.col, want.row, want.word, want.scrolled);
          $display("%0t:           got col %0d row %0d word %h scrolled %0b",
                   $realtime, got.col, got.row, got.word, got.scrolled);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  cfg_index_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tct_item_if item_ch ();
  tct_result_if result_ch ();

  text_console_teletype #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item(item_ch),
    .result(result_ch)
  );

  console_scoreboard sb;
  bit calm = 1'b0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int stall_left = 0;
  longint cycle_count = 0;
  console_result_t taken;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: check each transfer, then decide whether to stall
  always @(posedge clk) begin
    if (result_ch.valid && result_ch.ready) begin
      taken.col = result_ch.cursor_col;
      taken.row = result_ch.cursor_row;
      taken.word = result_ch.cell_word;
      taken.scrolled = result_ch.scrolled;
      sb.check_result(taken);
    end
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 24) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [CODE_W-1:0] code,
                           input logic [INDEX_W-1:0] index);
    item_ch.valid <= 1'b1;
    item_ch.kind <= kind;
    item_ch.char_code <= code;
    item_ch.cell_index <= index;
    do @(posedge clk); while (!item_ch.ready);
    sb.note_item(kind, code, index);
    if (!calm && $urandom_range(0, 11) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic settle();
    item_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_registers(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg,
                                   input logic [TAB_W-1:0] stride);
    logic [CFG_DATA_W-1:0] data;
    data = {1'($urandom_range(0, 1)), fg};
    cfg_we <= 1'b1;
    cfg_index <= CFG_FOREGROUND;
    cfg_data <= data;
    sb.set_register(CFG_FOREGROUND, data);
    @(posedge clk);
    data = {1'($urandom_range(0, 1)), bg};
    cfg_index <= CFG_BACKGROUND;
    cfg_data <= data;
    sb.set_register(CFG_BACKGROUND, data);
    @(posedge clk);
    cfg_index <= CFG_TAB_STRIDE;
    cfg_data <= stride;
    sb.set_register(CFG_TAB_STRIDE, stride);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int pick;
    logic [KIND_W-1:0] kind;
    logic [CODE_W-1:0] code;
    logic [INDEX_W-1:0] index;

    sb = new();
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_FOREGROUND;
    cfg_data <= '0;
    item_ch.valid <= 1'b0;
    item_ch.kind <= KIND_PUT;
    item_ch.char_code <= '0;
    item_ch.cell_index <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part under the reset colors and tab stride
    send_item(KIND_PUT, 8'h41, 11'h7FF);
    send_item(KIND_PUT, CH_SPACE, 11'h000);
    send_item(KIND_PUT, CH_PRINT_LAST, 11'h2AA);
    send_item(KIND_PUT, 8'h80, 11'h555);
    send_item(KIND_PUT, 8'hFF, 11'h000);
    send_item(KIND_PUT, 8'h00, 11'h7FF);
    send_item(KIND_PUT, 8'h1F, 11'h000);
    send_item(KIND_PUT, CH_BS, 11'h000);
    send_item(KIND_PUT, CH_TAB, 11'h000);
    send_item(KIND_PUT, CH_CR, 11'h000);
    send_item(KIND_PUT, CH_BS, 11'h000);
    send_item(KIND_READ, 8'hFF, 11'd0);
    send_item(KIND_READ, 8'h00, 11'd1);
    send_item(KIND_READ, 8'h55, 11'd1999);
    send_item(KIND_READ, 8'hAA, 11'd2000);
    send_item(KIND_READ, 8'h00, 11'h7FF);
    send_item(KIND_UNUSED, 8'hAA, 11'h555);
    send_item(KIND_PUT, CH_LF, 11'h000);
    send_item(KIND_PUT, 8'h7E, 11'h000);
    send_item(KIND_READ, 8'h00, 11'd80);
    send_item(KIND_CLEAR, 8'hFF, 11'h7FF);
    send_item(KIND_READ, 8'h00, 11'd0);
    send_item(KIND_PUT, CH_TAB, 11'h000);
    settle();

    for (int phase = 1; phase <= PHASES; phase++) begin
      case (phase)
        1: program_registers(4'h0, 4'hF, 5'd1);
        2: program_registers(4'hF, 4'hF, 5'd16);
        3: program_registers(4'h0, 4'h0, 5'd0);
        4: program_registers(COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)),
                             5'h1F);
        5: program_registers(COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)),
                             5'd3);
        default: program_registers(COLOR_W'($urandom_range(0, 15)),
                                   COLOR_W'($urandom_range(0, 15)),
                                   5'd1 << $urandom_range(0, 4));
      endcase
      if (phase == 2) hold_request = 1'b1;
      if (phase == PHASES) calm = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        kind = KIND_PUT;
        code = CODE_W'($urandom_range(CH_SPACE, CH_PRINT_LAST));
        index = INDEX_W'($urandom_range(0, 2047));
        if (pick < 62) begin
        end else if (pick < 68) begin
          code = CH_LF;
        end else if (pick < 72) begin
          code = CH_CR;
        end else if (pick < 77) begin
          code = CH_TAB;
        end else if (pick < 81) begin
          code = CH_BS;
        end else if (pick < 86) begin
          // codes below the space, the handled control codes among them, or the high half of the byte range
          code = $urandom_range(0, 1) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(128, 255));
        end else if (pick < 96) begin
          kind = KIND_READ;
          code = CODE_W'($urandom_range(0, 255));
          if ($urandom_range(0, 1))
            index = INDEX_W'(sb.row * COLUMNS + $urandom_range(0, COLUMNS - 1));
          else if ($urandom_range(0, 9) == 0)
            index = INDEX_W'($urandom_range(CELLS - 1, 2047));
          else
            index = INDEX_W'($urandom_range(0, CELLS - 1));
        end else if (pick < 98) begin
          kind = KIND_UNUSED;
          code = CODE_W'($urandom_range(0, 255));
        end else if (pick < 99) begin
          kind = KIND_CLEAR;
          code = CODE_W'($urandom_range(0, 255));
        end
        send_item(kind, code, index);
      end
      settle();
    end

    $display("ran %0d items under %0d register settings: %0d reads, %0d clears, %0d scrolls",
             sb.noted, PHASES + 1, sb.reads, sb.clears, sb.scrolls);
    $display("%0d results checked, %0d mismatches, %0d outstanding",
             sb.checked, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- text_console_teletype.f -----
+incdir+hdl
hdl/tct_pkg.sv
hdl/tct_ifs.sv
hdl/tct_datapath.sv
hdl/tct_ctrl.sv
hdl/text_console_teletype.sv
bench/text_console_teletype_tb.sv
